// ===== design/imr_pkg.sv =====
package imr_pkg;

	// Store sizes
	localparam int RAM_BANK_BYTES_DEF = 4096;
	localparam int BOOT_ROM_BYTES_DEF = 256;
	localparam int HIGH_RAM_BYTES     = 127;

	// Bus operations
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	// Map targets
	typedef logic [3:0] sel_t;
	localparam sel_t SEL_NONE    = 4'd0;
	localparam sel_t SEL_WRAM_LO = 4'd1;
	localparam sel_t SEL_WRAM_HI = 4'd2;
	localparam sel_t SEL_HRAM    = 4'd3;
	localparam sel_t SEL_IE      = 4'd4;
	localparam sel_t SEL_IF      = 4'd5;
	localparam sel_t SEL_BOOTCTL = 4'd6;
	localparam sel_t SEL_SPEED   = 4'd7;
	localparam sel_t SEL_BOOTROM = 4'd8;

	// Register addresses
	localparam logic [15:0] ADDR_IE      = 16'hFFFF;
	localparam logic [15:0] ADDR_IF      = 16'hFF0F;
	localparam logic [15:0] ADDR_BOOTCTL = 16'hFF50;
	localparam logic [15:0] ADDR_SPEED   = 16'hFF4D;
	localparam logic [15:0] ADDR_OVL_END = 16'h00FF;

	// Decoded request
	typedef struct packed {
		logic rd;
		logic wr;
		logic ld;
		sel_t sel;
	} dec_t;

endpackage

// ===== design/imr_decode.sv =====
module imr_decode (
	input  logic [1:0]   op,
	input  logic [15:0]  address,
	input  logic         overlay_on,
	input  logic         boot_loaded,
	output imr_pkg::dec_t dec
);
	import imr_pkg::*;

	// Classify the operation, then map the address to a target;
	// the boot overlay wins over everything
	always_comb begin
		dec.rd = (op == OP_READ);
		dec.wr = (op == OP_WRITE);
		dec.ld = (op == OP_LOAD);
		if (overlay_on && address <= ADDR_OVL_END) begin
			dec.sel = boot_loaded ? SEL_BOOTROM : SEL_NONE;
		end else if (address inside {[16'hC000:16'hCFFF], [16'hE000:16'hEFFF]}) begin
			dec.sel = SEL_WRAM_LO;
		end else if (address inside {[16'hD000:16'hDFFF], [16'hF000:16'hFDFF]}) begin
			dec.sel = SEL_WRAM_HI;
		end else if (address inside {[16'hFF80:16'hFFFE]}) begin
			dec.sel = SEL_HRAM;
		end else if (address == ADDR_IE) begin
			dec.sel = SEL_IE;
		end else if (address == ADDR_IF) begin
			dec.sel = SEL_IF;
		end else if (address == ADDR_BOOTCTL) begin
			dec.sel = SEL_BOOTCTL;
		end else if (address == ADDR_SPEED) begin
			dec.sel = SEL_SPEED;
		end else begin
			dec.sel = SEL_NONE;
		end
	end

endmodule

// ===== design/imr_ram.sv =====
module imr_ram #(
	parameter int DEPTH = imr_pkg::RAM_BANK_BYTES_DEF,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	import imr_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== design/internal_ram_and_register_map.sv =====
// Byte-wide bus map with two work-RAM banks (mirrored at E000-FDFF), high RAM,
// four control registers and a loadable boot ROM that overlays 0000-00FF while
// boot control is zero. A request is taken on start while busy is low; busy is
// never raised, so a request may be issued every cycle. Each request yields
// exactly one result: done pulses for one cycle, in the cycle after the request,
// with read_data valid in that cycle (zero for anything but a read). The
// receiver cannot stall and must take the result in that cycle. The latency is
// set by the registered read port of the RAMs; a write or register update lands
// at the accepting edge, so the next request already sees it.
module internal_ram_and_register_map #(
	parameter int RAM_BANK_BYTES = imr_pkg::RAM_BANK_BYTES_DEF,
	parameter int BOOT_ROM_BYTES = imr_pkg::BOOT_ROM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        done,
	output logic [7:0]  read_data
);
	import imr_pkg::*;

	localparam int BANK_AW = $clog2(RAM_BANK_BYTES);
	localparam int BOOT_AW = $clog2(BOOT_ROM_BYTES);
	localparam int HRAM_AW = $clog2(HIGH_RAM_BYTES);

	logic       accept;
	dec_t       dec;
	logic       boot_loaded_q;
	logic [7:0] boot_ctl_q;
	logic [7:0] irq_enable_q;
	logic [7:0] irq_flags_q;
	logic [7:0] speed_q;

	logic       done_s1;
	logic       rd_s1;
	sel_t       sel_s1;
	logic [7:0] reg_s1;

	logic [7:0] wlo_rdata;
	logic [7:0] whi_rdata;
	logic [7:0] hram_rdata;
	logic [7:0] boot_rdata;
	logic [BOOT_AW-1:0] boot_addr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	imr_decode u_decode (
		.op          (op),
		.address     (address),
		.overlay_on  (boot_ctl_q == 8'd0),
		.boot_loaded (boot_loaded_q),
		.dec         (dec)
	);

	// Work RAM banks, high RAM and boot ROM
	imr_ram #(.DEPTH(RAM_BANK_BYTES), .WIDTH(8)) u_wram_lo (
		.clk   (clk),
		.we    (accept && dec.wr && dec.sel == SEL_WRAM_LO),
		.re    (accept && dec.rd && dec.sel == SEL_WRAM_LO),
		.addr  (address[BANK_AW-1:0]),
		.wdata (data),
		.rdata (wlo_rdata)
	);

	imr_ram #(.DEPTH(RAM_BANK_BYTES), .WIDTH(8)) u_wram_hi (
		.clk   (clk),
		.we    (accept && dec.wr && dec.sel == SEL_WRAM_HI),
		.re    (accept && dec.rd && dec.sel == SEL_WRAM_HI),
		.addr  (address[BANK_AW-1:0]),
		.wdata (data),
		.rdata (whi_rdata)
	);

	imr_ram #(.DEPTH(HIGH_RAM_BYTES), .WIDTH(8)) u_hram (
		.clk   (clk),
		.we    (accept && dec.wr && dec.sel == SEL_HRAM),
		.re    (accept && dec.rd && dec.sel == SEL_HRAM),
		.addr  (address[HRAM_AW-1:0]),
		.wdata (data),
		.rdata (hram_rdata)
	);

	assign boot_addr = address[BOOT_AW-1:0];

	imr_ram #(.DEPTH(BOOT_ROM_BYTES), .WIDTH(8)) u_boot (
		.clk   (clk),
		.we    (accept && dec.ld),
		.re    (accept && dec.rd && dec.sel == SEL_BOOTROM),
		.addr  (boot_addr),
		.wdata (data),
		.rdata (boot_rdata)
	);

	// Update control registers on an accepted write or boot load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_loaded_q <= 1'b0;
			boot_ctl_q    <= 8'hFF;
			irq_enable_q  <= 8'd0;
			irq_flags_q   <= 8'd0;
			speed_q       <= 8'd0;
		end else if (accept) begin
			if (dec.ld) begin
				boot_loaded_q <= 1'b1;
				boot_ctl_q    <= 8'd0;
			end else if (dec.wr) begin
				case (dec.sel)
					SEL_IE:      irq_enable_q <= data;
					SEL_IF:      irq_flags_q  <= data;
					SEL_BOOTCTL: boot_ctl_q   <= data;
					SEL_SPEED:   speed_q      <= data;
					default: ;
				endcase
			end
		end
	end

	// Advance the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Hold the decoded target and any register value for the result cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= dec.rd;
			sel_s1 <= dec.sel;
			case (dec.sel)
				SEL_IE:      reg_s1 <= irq_enable_q;
				SEL_IF:      reg_s1 <= irq_flags_q;
				SEL_BOOTCTL: reg_s1 <= boot_ctl_q;
				SEL_SPEED:   reg_s1 <= speed_q;
				default:     reg_s1 <= 8'd0;
			endcase
		end
	end

	// Select the result byte
	always_comb begin
		read_data = 8'd0;
		if (rd_s1) begin
			case (sel_s1)
				SEL_WRAM_LO: read_data = wlo_rdata;
				SEL_WRAM_HI: read_data = whi_rdata;
				SEL_HRAM:    read_data = hram_rdata;
				SEL_BOOTROM: read_data = boot_rdata;
				SEL_IE, SEL_IF, SEL_BOOTCTL, SEL_SPEED: read_data = reg_s1;
				default:     read_data = 8'd0;
			endcase
		end
	end

	assign done = done_s1;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imr_pkg::*;

	// Op code that the block must treat as a no-op
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 100000;
	localparam int TAIL_CYCLES = 4;
	localparam int RECENT_DEPTH = 64;
	localparam int PRINT_CAP = 50;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  data;
	logic        done;
	logic [7:0]  read_data;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] address;
		logic [7:0]  read_data;
	} access_t;

	// Expected read bytes, oldest request first
	access_t expected_bytes[$];
	access_t oldest;

	// Shadow copy of the bus map
	logic [7:0] wram_lo_m [RAM_BANK_BYTES_DEF];
	logic [7:0] wram_hi_m [RAM_BANK_BYTES_DEF];
	logic [7:0] hram_m [HIGH_RAM_BYTES];
	logic [7:0] boot_rom_m [BOOT_ROM_BYTES_DEF];
	bit         wram_lo_set [RAM_BANK_BYTES_DEF];
	bit         wram_hi_set [RAM_BANK_BYTES_DEF];
	bit         hram_set [HIGH_RAM_BYTES];
	bit         boot_rom_set [BOOT_ROM_BYTES_DEF];
	bit         boot_loaded_m;
	logic [7:0] boot_ctl_m;
	logic [7:0] irq_en_m;
	logic [7:0] irq_flags_m;
	logic [7:0] speed_m;

	// Addresses of recently written store cells, used to aim reads
	logic [15:0] recent_cells[$];

	int          errors = 0;
	int unsigned cycles = 0;

	internal_ram_and_register_map dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.address  (address),
		.data     (data),
		.done     (done),
		.read_data(read_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL internal_ram_and_register_map");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [1:0] o,
			input logic [15:0] a, input logic [7:0] want, input logic [7:0] got);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at %0t: %s op %0d addr %h expected %h got %h",
				$time, what, o, a, want, got);
	endtask

	// Check each result against the oldest pending request
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("result with no request pending", 2'd0, 16'h0, 8'h0, read_data);
			end else begin
				oldest = expected_bytes.pop_front();
				if (read_data !== oldest.read_data)
					report_mismatch("read_data", oldest.op, oldest.address, oldest.read_data,
						read_data);
			end
		end
	end

	function automatic void locate(input logic [15:0] a, output sel_t sel, output int off);
		off = 0;
		if (a >= 16'hC000 && a <= 16'hCFFF) begin
			sel = SEL_WRAM_LO;
			off = a - 16'hC000;
		end else if (a >= 16'hD000 && a <= 16'hDFFF) begin
			sel = SEL_WRAM_HI;
			off = a - 16'hD000;
		end else if (a >= 16'hE000 && a <= 16'hEFFF) begin
			sel = SEL_WRAM_LO;
			off = a - 16'hE000;
		end else if (a >= 16'hF000 && a <= 16'hFDFF) begin
			sel = SEL_WRAM_HI;
			off = a - 16'hF000;
		end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
			sel = SEL_HRAM;
			off = a - 16'hFF80;
		end else if (a == ADDR_IE) begin
			sel = SEL_IE;
		end else if (a == ADDR_IF) begin
			sel = SEL_IF;
		end else if (a == ADDR_BOOTCTL) begin
			sel = SEL_BOOTCTL;
		end else if (a == ADDR_SPEED) begin
			sel = SEL_SPEED;
		end else begin
			sel = SEL_NONE;
		end
	endfunction

	function automatic bit overlay_on(input logic [15:0] a);
		return boot_ctl_m == 8'h00 && a <= ADDR_OVL_END;
	endfunction

	// True when a read at a returns a byte that was defined by a write, a boot load or a reset
	function automatic bit defined_read(input logic [15:0] a);
		sel_t sel;
		int   off;
		if (overlay_on(a))
			return !boot_loaded_m || boot_rom_set[a[7:0]];
		locate(a, sel, off);
		case (sel)
			SEL_WRAM_LO: return wram_lo_set[off];
			SEL_WRAM_HI: return wram_hi_set[off];
			SEL_HRAM:    return hram_set[off];
			default:     return 1'b1;
		endcase
	endfunction

	function automatic void remember(input logic [15:0] a);
		recent_cells.push_back(a);
		if (recent_cells.size() > RECENT_DEPTH)
			void'(recent_cells.pop_front());
	endfunction

	// Apply one bus access to the shadow map and return the byte it reads
	function automatic logic [7:0] bus_access(input logic [1:0] o, input logic [15:0] a,
			input logic [7:0] d);
		sel_t       sel;
		int         off;
		bit         ovl;
		logic [7:0] rd;
		rd = 8'h00;
		ovl = overlay_on(a);
		locate(a, sel, off);
		case (o)
			OP_READ: begin
				if (ovl) begin
					rd = boot_loaded_m ? boot_rom_m[a[7:0]] : 8'h00;
				end else begin
					case (sel)
						SEL_WRAM_LO: rd = wram_lo_m[off];
						SEL_WRAM_HI: rd = wram_hi_m[off];
						SEL_HRAM:    rd = hram_m[off];
						SEL_IE:      rd = irq_en_m;
						SEL_IF:      rd = irq_flags_m;
						SEL_BOOTCTL: rd = boot_ctl_m;
						SEL_SPEED:   rd = speed_m;
						default:     rd = 8'h00;
					endcase
				end
			end
			OP_WRITE: begin
				if (!ovl) begin
					case (sel)
						SEL_WRAM_LO: begin
							wram_lo_m[off] = d;
							wram_lo_set[off] = 1'b1;
							remember(a);
						end
						SEL_WRAM_HI: begin
							wram_hi_m[off] = d;
							wram_hi_set[off] = 1'b1;
							remember(a);
						end
						SEL_HRAM: begin
							hram_m[off] = d;
							hram_set[off] = 1'b1;
							remember(a);
						end
						SEL_IE:      irq_en_m = d;
						SEL_IF:      irq_flags_m = d;
						SEL_BOOTCTL: boot_ctl_m = d;
						SEL_SPEED:   speed_m = d;
						default: ;
					endcase
				end
			end
			OP_LOAD: begin
				boot_rom_m[a[7:0]] = d;
				boot_rom_set[a[7:0]] = 1'b1;
				boot_loaded_m = 1'b1;
				boot_ctl_m = 8'h00;
				remember({8'h00, a[7:0]});
			end
			default: ;
		endcase
		return rd;
	endfunction

	// Issue one request after an optional idle gap and record what it must return
	task automatic send_request(input logic [1:0] o, input logic [15:0] a,
			input logic [7:0] d, input int gap);
		access_t e;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		address <= a;
		data <= d;
		do @(posedge clk); while (busy);
		e.op = o;
		e.address = a;
		e.read_data = bus_access(o, a, d);
		expected_bytes.push_back(e);
	endtask

	// Hold off new requests until every result is back
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
	endtask

	function automatic int idle_gap(input int pct);
		int n;
		n = 0;
		while ($urandom_range(99) < pct && n < 40)
			n++;
		return n;
	endfunction

	function automatic logic [15:0] any_register();
		case ($urandom_range(3))
			0:       return ADDR_IE;
			1:       return ADDR_IF;
			2:       return ADDR_BOOTCTL;
			default: return ADDR_SPEED;
		endcase
	endfunction

	function automatic logic [15:0] mapped_address();
		case ($urandom_range(7))
			0, 1, 2: return 16'hC000 + 16'($urandom_range(16'h3DFF));
			3:       return 16'hFF80 + 16'($urandom_range(HIGH_RAM_BYTES - 1));
			4:       return 16'($urandom_range(ADDR_OVL_END));
			5:       return any_register();
			default: return 16'($urandom);
		endcase
	endfunction

	// Aim most reads at cells written lately, half of those with a mirror through it
	function automatic logic [15:0] read_address();
		logic [15:0] a;
		if (recent_cells.size() > 0 && $urandom_range(99) < 65) begin
			a = recent_cells[$urandom_range(recent_cells.size() - 1)];
			if ($urandom_range(1)) begin
				if (a >= 16'hC000 && a <= 16'hDDFF)
					a = a + 16'h2000;
				else if (a >= 16'hE000 && a <= 16'hFDFF)
					a = a - 16'h2000;
			end
		end else begin
			a = mapped_address();
		end
		return a;
	endfunction

	task automatic test_reset_values();
		send_request(OP_READ, ADDR_IE, 8'h00, 0);
		send_request(OP_READ, ADDR_IF, 8'h00, 0);
		send_request(OP_READ, ADDR_SPEED, 8'h00, 0);
		send_request(OP_READ, ADDR_BOOTCTL, 8'h00, 0);
		send_request(OP_READ, 16'h0000, 8'h00, 0);
		send_request(OP_UNKNOWN, ADDR_IE, 8'hFF, 0);
		send_request(OP_READ, ADDR_IE, 8'h00, 0);
		wait_for_results();
	endtask

	task automatic test_registers_and_unmapped();
		send_request(OP_WRITE, ADDR_IE, 8'hFF, 0);
		send_request(OP_WRITE, ADDR_SPEED, 8'hA5, 1);
		send_request(OP_READ, ADDR_IE, 8'h00, 0);
		send_request(OP_READ, ADDR_SPEED, 8'h00, 0);
		send_request(OP_WRITE, 16'hFEA0, 8'hFF, 0);
		send_request(OP_READ, 16'hFEA0, 8'h00, 0);
		send_request(OP_READ, 16'hFEFF, 8'h00, 2);
		wait_for_results();
	endtask

	task automatic test_work_and_high_ram();
		send_request(OP_WRITE, 16'hC000, 8'h5A, 0);
		send_request(OP_READ, 16'hE000, 8'h00, 0);
		send_request(OP_WRITE, 16'hFDFF, 8'hFF, 0);
		send_request(OP_READ, 16'hDDFF, 8'h00, 0);
		send_request(OP_WRITE, 16'hFF80, 8'h01, 0);
		send_request(OP_WRITE, 16'hFFFE, 8'h80, 0);
		send_request(OP_READ, 16'hFF80, 8'h00, 0);
		send_request(OP_READ, 16'hFFFE, 8'h00, 0);
		wait_for_results();
	endtask

	task automatic test_boot_overlay();
		// Overlay on with nothing loaded reads zero
		send_request(OP_WRITE, ADDR_BOOTCTL, 8'h00, 0);
		send_request(OP_READ, ADDR_OVL_END, 8'h00, 0);
		// Load turns the overlay on; only the low address byte selects the cell
		send_request(OP_LOAD, 16'h1200, 8'hC3, 0);
		send_request(OP_LOAD, 16'hFFFF, 8'h7E, 0);
		send_request(OP_READ, 16'h0000, 8'h00, 0);
		send_request(OP_READ, ADDR_OVL_END, 8'h00, 0);
		send_request(OP_WRITE, 16'h0000, 8'h11, 0);
		send_request(OP_READ, 16'h0000, 8'h00, 0);
		send_request(OP_READ, ADDR_BOOTCTL, 8'h00, 0);
		send_request(OP_WRITE, ADDR_BOOTCTL, 8'h01, 0);
		send_request(OP_READ, ADDR_OVL_END, 8'h00, 0);
		wait_for_results();
	endtask

	task automatic test_random(input int count, input int idle_pct);
		logic [1:0]  o;
		logic [15:0] a;
		logic [7:0]  d;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(99);
			d = 8'($urandom);
			if (pick < 40) begin
				o = OP_READ;
				a = read_address();
			end else if (pick < 75) begin
				o = OP_WRITE;
				a = mapped_address();
			end else if (pick < 82) begin
				o = OP_LOAD;
				a = 16'($urandom);
			end else if (pick < 86) begin
				o = OP_UNKNOWN;
				a = 16'($urandom);
			end else if (pick < 93) begin
				o = OP_WRITE;
				a = any_register();
				if (a == ADDR_BOOTCTL && $urandom_range(1))
					d = 8'h00;
			end else begin
				o = $urandom_range(1) ? OP_READ : OP_WRITE;
				a = 16'($urandom);
			end
			// Retarget reads of never-written cells to the unused hole
			if (o == OP_READ && !defined_read(a))
				a = 16'hFEA0 + 16'($urandom_range(95));
			if ($urandom_range(199) == 0)
				wait_for_results();
			send_request(o, a, d, idle_gap(idle_pct));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_READ;
		address = 16'h0000;
		data = 8'h00;
		boot_loaded_m = 1'b0;
		boot_ctl_m = 8'hFF;
		irq_en_m = 8'h00;
		irq_flags_m = 8'h00;
		speed_m = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_registers_and_unmapped();
		test_work_and_high_ram();
		test_boot_overlay();
		test_random(300, 0);
		wait_for_results();
		test_random(300, 71);
		test_random(300, 23);
		test_random(200, 0);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS internal_ram_and_register_map");
		else
			$display("FAIL internal_ram_and_register_map");
		$finish;
	end

endmodule
